// ===== hdl/lifo_stack_sorted_insert_unit_assert.svh =====
// ----------------------------------------------------------------------------
// lifo_stack_sorted_insert_unit_assert.svh
// Assertion macros used by the checker file of the stack unit.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_SORTED_INSERT_UNIT_ASSERT_SVH
`define LIFO_STACK_SORTED_INSERT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LSSI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack unit check failed");

// Next-cycle implication, disabled while reset is high.
`define LSSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack unit check failed");

`endif

// ===== hdl/lssi_pkg.sv =====
// ----------------------------------------------------------------------------
// lssi_pkg
// Types, codes and defaults of the sorted-insert LIFO stack unit.
// ----------------------------------------------------------------------------
package lssi_pkg;

  localparam int VALUE_W = 32;
  localparam int DEPTH_W = 7;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_WORD_WIDTH  = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_MARK = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PEEK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MEMBER   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [VALUE_W-1:0] value;
    logic [DEPTH_W-1:0] mark_depth;
  } lssi_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic [DEPTH_W-1:0] depth_now;
    logic               found;
    logic               at_mark;
    logic [STAT_W-1:0]  status;
  } lssi_res_t;

  typedef struct packed {
    logic load;   // take the request word
    logic shift;  // take the word of the cell below
  } lssi_cell_ctl_t;

endpackage

// ===== hdl/lssi_cell.sv =====
// ----------------------------------------------------------------------------
// lssi_cell
// One stack entry: holds a word, compares it with the request word, and
// loads the request word or the word of its lower neighbor.
// ----------------------------------------------------------------------------
module lssi_cell
  import lssi_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  lssi_cell_ctl_t        ctl,
  input  logic [WORD_WIDTH-1:0] val,
  input  logic [WORD_WIDTH-1:0] below,
  input  logic                  rd_sel,
  output logic [WORD_WIDTH-1:0] word,
  output logic                  le,
  output logic                  eq,
  output logic [WORD_WIDTH-1:0] rd_word
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= val;
    end else if (ctl.shift) begin
      word <= below;
    end
  end

  assign le      = (word <= val);
  assign eq      = (word == val);
  assign rd_word = rd_sel ? word : '0;

endmodule

// ===== hdl/lifo_stack_sorted_insert_unit.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_sorted_insert_unit
// Bounded LIFO stack with push, pop, pop to mark, peek, ordered insert,
// member test and clear.
// ----------------------------------------------------------------------------
// A request accepted at one clock edge has its result on the result port, with
// done high, in the following cycle, and a new request may be issued in every
// cycle, so busy stays low. This rests on the row of entry cells, which compare
// against the request word and shift toward the top all in the same cycle.
// The result is shown for one cycle only and must be taken then. Entries that
// were never written hold no defined value, but only entries below the depth
// are ever read.
module lifo_stack_sorted_insert_unit
  import lssi_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,  // 2 .. 127
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH    // 1 .. 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  lssi_req_t request,
  output lssi_res_t result,
  output logic      done
);

  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (CW > DEPTH_W) ? CW : DEPTH_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [WORD_WIDTH-1:0] val;
  logic [WORD_WIDTH-1:0] word [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rd_word [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rd_data;

  logic [STACK_DEPTH-1:0] le_vec;
  logic [STACK_DEPTH-1:0] eq_vec;
  logic [STACK_DEPTH-1:0] valid;
  logic [STACK_DEPTH-1:0] hit;
  logic [STACK_DEPTH:0]   above;   // hit somewhere at this index or higher
  logic [STACK_DEPTH-1:0] top_eq;  // equal word that is the highest hit
  logic [STACK_DEPTH-1:0] pos_is;
  logic [STACK_DEPTH-1:0] shift_ok;
  logic [STACK_DEPTH-1:0] rd_sel;

  lssi_cell_ctl_t ctl [STACK_DEPTH];

  logic accept;
  logic full;
  logic dup;
  logic member;
  logic do_push;
  logic do_ins;

  lssi_res_t res_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign val    = request.value[WORD_WIDTH-1:0];
  assign full   = (count == CW'(STACK_DEPTH));

  assign above[STACK_DEPTH] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      assign valid[gi]  = (CW'(gi) < count);
      assign hit[gi]    = valid[gi] && le_vec[gi];
      assign above[gi]  = |hit[STACK_DEPTH-1:gi];
      assign top_eq[gi] = valid[gi] && eq_vec[gi] && !above[gi+1];
      assign rd_sel[gi] = (count != '0) && (CW'(gi) == count - 1'b1);

      if (gi == 0) begin : g_bottom
        assign pos_is[gi]   = !above[0];
        assign shift_ok[gi] = 1'b0;
      end else begin : g_upper
        assign pos_is[gi]   = hit[gi-1] && !above[gi];
        assign shift_ok[gi] = !above[gi-1] && (CW'(gi) <= count);
      end

      assign ctl[gi].load  = (do_push && (CW'(gi) == count)) || (do_ins && pos_is[gi]);
      assign ctl[gi].shift = do_ins && shift_ok[gi];

      lssi_cell #(
        .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
        .clk    (clk),
        .ctl    (ctl[gi]),
        .val    (val),
        .below  ((gi == 0) ? '0 : word[(gi == 0) ? 0 : gi-1]),
        .rd_sel (rd_sel[gi]),
        .word   (word[gi]),
        .le     (le_vec[gi]),
        .eq     (eq_vec[gi]),
        .rd_word(rd_word[gi])
      );
    end
  endgenerate

  assign dup    = |top_eq;
  assign member = |(valid & eq_vec);

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      rd_data = rd_data | rd_word[i];
    end
  end

  always_comb begin
    count_next         = count;
    do_push            = 1'b0;
    do_ins             = 1'b0;
    res_next.out_value = '0;
    res_next.found     = 1'b0;
    res_next.status    = ST_OK;
    case (request.action)
      ACT_PUSH: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else begin
          do_push    = accept;
          count_next = count + 1'b1;
        end
      end
      ACT_POP: begin
        if (count == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          count_next         = count - 1'b1;
          res_next.out_value = VALUE_W'(rd_data);
        end
      end
      ACT_POP_MARK: begin
        // a mark above the depth empties the stack
        if (CMPW'(count) > CMPW'(request.mark_depth)) begin
          count_next = CW'(request.mark_depth);
        end else if (CMPW'(count) < CMPW'(request.mark_depth)) begin
          count_next = '0;
        end
      end
      ACT_PEEK: begin
        if (count == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.out_value = VALUE_W'(rd_data);
        end
      end
      ACT_INSERT: begin
        // duplicate check goes before the full check
        if (dup) begin
          res_next.status = ST_DUP;
        end else if (full) begin
          res_next.status = ST_FULL;
        end else begin
          do_ins         = accept;
          count_next     = count + 1'b1;
          res_next.found = 1'b1;
        end
      end
      ACT_MEMBER: begin
        res_next.found = member;
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    res_next.depth_now = DEPTH_W'(count_next);
    res_next.at_mark   = (CMPW'(count_next) == CMPW'(request.mark_depth));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // hold the result payload; done marks its single valid cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
  end

endmodule

// ===== hdl/lssi_chk.sv =====
// ----------------------------------------------------------------------------
// lssi_chk
// Port-level checks of the stack unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "lifo_stack_sorted_insert_unit_assert.svh"

module lssi_chk
  import lssi_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input lssi_res_t result,
  input logic      done
);

  logic res_empty;
  logic res_zero;

  assign res_empty = done && (result.status == ST_EMPTY);
  assign res_zero  = (result.out_value == '0) && (result.depth_now == '0);

  `LSSI_ASSERT_NEXT(a_done_after_accept, clk, rst, start && !busy, done)
  `LSSI_ASSERT_NEXT(a_no_done_unasked, clk, rst, !(start && !busy), !done)
  `LSSI_ASSERT_NOW(a_depth_bound, clk, rst, done, result.depth_now <= STACK_DEPTH)
  `LSSI_ASSERT_NOW(a_empty_result, clk, rst, res_empty, res_zero)

endmodule

bind lifo_stack_sorted_insert_unit lssi_chk #(
  .STACK_DEPTH(STACK_DEPTH)
) u_lssi_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);

// ===== test/tb_lifo_stack_sorted_insert_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted-insert LIFO stack unit.
// ----------------------------------------------------------------------------
// Requests go in through the start/busy handshake with random gaps. Each
// accepted item updates a local copy of the stack and queues the result it
// must produce. Every done pulse is checked field by field against the oldest
// queued result. Directed items cover the empty and boundary cases, then
// random phases fill the stack, run ordered inserts and mix every operation.
module tb;
  import lssi_pkg::*;

  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  lssi_req_t request = '0;
  lssi_res_t result;
  logic      done;

  // local copy of the stack, index 0 is the bottom
  logic [VALUE_W-1:0] stack_words [0:STACK_DEPTH-1];
  int                 stack_count = 0;
  lssi_res_t          pending_results [$];

  int items_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int deepest = 0;
  int full_hits = 0;
  int dup_hits = 0;
  int stall_cycles = 0;

  lifo_stack_sorted_insert_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .result  (result),
    .done    (done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Apply one request to the local stack and return the result it causes.
  function automatic lssi_res_t apply_stack_op(input lssi_req_t req);
    lssi_res_t res;
    int        slot;
    bit        dup;
    res = '0;
    res.status = ST_OK;
    slot = 0;
    dup = 1'b0;
    case (req.action)
      ACT_PUSH: begin
        if (stack_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_words[stack_count] = req.value;
          stack_count++;
        end
      end
      ACT_POP: begin
        if (stack_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          stack_count--;
          res.out_value = stack_words[stack_count];
        end
      end
      ACT_POP_MARK: begin
        if (stack_count > int'(req.mark_depth)) stack_count = int'(req.mark_depth);
        else if (stack_count < int'(req.mark_depth)) stack_count = 0;
      end
      ACT_PEEK: begin
        if (stack_count == 0) res.status = ST_EMPTY;
        else res.out_value = stack_words[stack_count-1];
      end
      ACT_INSERT: begin
        // find the highest entry not above the word; insert just over it
        for (int i = stack_count - 1; i >= 0; i--) begin
          if (stack_words[i] <= req.value) begin
            dup = (stack_words[i] == req.value);
            slot = i + 1;
            break;
          end
        end
        if (dup) begin
          res.status = ST_DUP;
        end else if (stack_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = stack_count; i > slot; i--) stack_words[i] = stack_words[i-1];
          stack_words[slot] = req.value;
          stack_count++;
          res.found = 1'b1;
        end
      end
      ACT_MEMBER: begin
        for (int i = 0; i < stack_count; i++) begin
          if (stack_words[i] == req.value) res.found = 1'b1;
        end
      end
      ACT_CLEAR: begin
        stack_count = 0;
      end
      default: begin
      end
    endcase
    res.depth_now = stack_count[DEPTH_W-1:0];
    res.at_mark = (stack_count == int'(req.mark_depth));
    if (stack_count > deepest) deepest = stack_count;
    if (res.status == ST_FULL) full_hits++;
    if (res.status == ST_DUP) dup_hits++;
    return res;
  endfunction

  function automatic lssi_req_t make_req(input logic [ACT_W-1:0] act,
                                         input logic [VALUE_W-1:0] val,
                                         input logic [DEPTH_W-1:0] mark);
    lssi_req_t req;
    req.action = act;
    req.value = val;
    req.mark_depth = mark;
    return req;
  endfunction

  // Small or near-maximum words half the time, so duplicates and ordering ties occur.
  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom_range(0, 31));
      1: return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 31));
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // Half the time a word held on the stack, when there is one; else a random word.
  function automatic logic [VALUE_W-1:0] held_or_random_word();
    if (stack_count > 0 && $urandom_range(0, 1) == 1)
      return stack_words[$urandom_range(0, stack_count - 1)];
    return random_word();
  endfunction

  // Marks cluster around the current depth so at_mark and pop to mark hit.
  function automatic logic [DEPTH_W-1:0] random_mark();
    int m;
    if ($urandom_range(0, 1) == 1) m = stack_count + int'($urandom_range(0, 4)) - 2;
    else m = int'($urandom_range(0, STACK_DEPTH));
    if (m < 0) m = 0;
    if (m > STACK_DEPTH) m = STACK_DEPTH;
    return m[DEPTH_W-1:0];
  endfunction

  // Drive one item after a random gap and hold it until it is taken.
  task automatic send_item(input lssi_req_t req);
    int gap;
    // every fourth stretch of items goes back to back
    if ((items_sent % 128) < 96) gap = int'($urandom_range(0, 5));
    else gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_stack_op(req));
    items_sent++;
  endtask

  task automatic check_field(input string field, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    lssi_res_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: %h", result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_value", want.out_value, result.out_value);
        check_field("depth_now", want.depth_now, result.depth_now);
        check_field("found", want.found, result.found);
        check_field("at_mark", want.at_mark, result.at_mark);
        check_field("status", want.status, result.status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_empty_stack();
    send_item(make_req(ACT_POP, 32'h0, 7'd0));
    send_item(make_req(ACT_PEEK, 32'hFFFF_FFFF, 7'd1));
    send_item(make_req(ACT_MEMBER, 32'h0, 7'd0));
    send_item(make_req(ACT_POP_MARK, 32'h0, 7'd0));
    send_item(make_req(ACT_POP_MARK, 32'h0, 7'd64));
    send_item(make_req(ACT_UNUSED, 32'h1234_5678, 7'd0));
  endtask

  task automatic test_basic_ops();
    send_item(make_req(ACT_PUSH, 32'h0, 7'd1));
    send_item(make_req(ACT_PUSH, 32'hFFFF_FFFF, 7'd2));
    send_item(make_req(ACT_PEEK, 32'h0, 7'd2));
    send_item(make_req(ACT_MEMBER, 32'hFFFF_FFFF, 7'd63));
    send_item(make_req(ACT_MEMBER, 32'h1234_5678, 7'd64));
    // lands between the two entries
    send_item(make_req(ACT_INSERT, 32'h8000_0000, 7'd3));
    send_item(make_req(ACT_INSERT, 32'h0, 7'd3));
    send_item(make_req(ACT_INSERT, 32'hFFFF_FFFF, 7'd0));
    send_item(make_req(ACT_POP, 32'h0, 7'd2));
    send_item(make_req(ACT_POP_MARK, 32'h0, 7'd1));
    // mark above the depth empties the stack
    send_item(make_req(ACT_POP_MARK, 32'h0, 7'd64));
    send_item(make_req(ACT_INSERT, 32'h5555_5555, 7'd1));
    send_item(make_req(ACT_INSERT, 32'hAAAA_AAAA, 7'd2));
    send_item(make_req(ACT_INSERT, 32'h0000_0001, 7'd3));
    send_item(make_req(ACT_MEMBER, 32'h5555_5555, 7'd0));
    send_item(make_req(ACT_CLEAR, 32'h0, 7'd0));
  endtask

  task automatic test_full_stack();
    repeat (2) begin
      send_item(make_req(ACT_CLEAR, random_word(), 7'd0));
      // even words only, so any odd word is known to be absent
      while (stack_count < STACK_DEPTH)
        send_item(make_req(ACT_PUSH, random_word() & ~32'h1, random_mark()));
      send_item(make_req(ACT_PUSH, random_word(), 7'd64));
      send_item(make_req(ACT_INSERT, random_word() | 32'h1, random_mark()));
      send_item(make_req(ACT_INSERT, stack_words[$urandom_range(0, STACK_DEPTH - 1)],
                         random_mark()));
      send_item(make_req(ACT_MEMBER, stack_words[$urandom_range(0, STACK_DEPTH - 1)],
                         random_mark()));
      send_item(make_req(ACT_PEEK, random_word(), 7'd64));
      send_item(make_req(ACT_POP_MARK, random_word(), 7'd64));
      send_item(make_req(ACT_POP, random_word(), random_mark()));
      send_item(make_req(ACT_PUSH, random_word(), random_mark()));
      send_item(make_req(ACT_POP_MARK, random_word(), 7'($urandom_range(0, 63))));
      send_item(make_req(ACT_POP_MARK, random_word(), 7'(stack_count + 1)));
    end
  endtask

  task automatic test_sorted_inserts(input int count);
    int                 r;
    logic [ACT_W-1:0]   act;
    repeat (count) begin
      r = int'($urandom_range(0, 99));
      if (r < 40) act = ACT_INSERT;
      else if (r < 60) act = ACT_MEMBER;
      else if (r < 70) act = ACT_POP;
      else if (r < 78) act = ACT_PEEK;
      else if (r < 88) act = ACT_POP_MARK;
      else if (r < 97) act = ACT_PUSH;
      else act = ACT_CLEAR;
      send_item(make_req(act, held_or_random_word(), random_mark()));
    end
  endtask

  task automatic test_random_mix(input int count);
    repeat (count)
      send_item(make_req(ACT_W'($urandom_range(0, 6)), held_or_random_word(),
                         random_mark()));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_basic_ops();
    test_full_stack();
    test_sorted_inserts(600);
    test_random_mix(600);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d items and checked %0d results; deepest stack %0d entries.",
             items_sent, results_seen, deepest);
    $display("Full stack rejections: %0d, duplicate inserts rejected: %0d.",
             full_hits, dup_hits);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== lifo_stack_sorted_insert_unit.f =====
+incdir+hdl
hdl/lssi_pkg.sv
hdl/lssi_cell.sv
hdl/lifo_stack_sorted_insert_unit.sv
hdl/lssi_chk.sv
test/tb_lifo_stack_sorted_insert_unit.sv
